### rtl/core/bod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bod_pkg
// Shared constants for the obstacle dilation block.
// ----------------------------------------------------------------------------
package bod_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 16;

  // window span in pixels along one axis
  localparam int SPAN   = 2 * MAX_RADIUS;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = COL_W + 1;
  localparam int CNT_W  = $clog2(SPAN + 1);
  localparam int RAD_W  = 5;
  localparam int REG_W  = 11;
  localparam int IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

  // saturated row distance: no hit within reach
  localparam logic [CNT_W-1:0] DIST_SAT = CNT_W'(SPAN);

endpackage

### rtl/core/bod_hspan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bod_hspan
// Horizontal window: keeps the last pixels of the stream and ORs those that
// fall in the same row as the evaluated column and inside its span.
// ----------------------------------------------------------------------------
module bod_hspan (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic                      occ_in,
  input  logic [bod_pkg::COL_W-1:0] col,
  input  logic [bod_pkg::REG_W-1:0] width,
  input  logic [bod_pkg::RAD_W-1:0] radius,
  output logic                      hit
);
  import bod_pkg::*;

  logic [SPAN-1:0] hist;
  logic [REG_W:0]  reach;
  logic [REG_W:0]  span_len;

  // newest pixel in bit 0
  always_ff @(posedge clk) begin
    if (shift_en) begin
      hist <= {hist[SPAN-2:0], occ_in};
    end
  end

  // tap t holds column col+radius-t of the evaluated row
  always_comb begin
    reach    = (REG_W+1)'(col) + (REG_W+1)'(radius);
    span_len = (REG_W+1)'({radius, 1'b0});
    hit      = 1'b0;
    for (int t = 0; t < SPAN; t++) begin
      if (hist[t] && ((REG_W+1)'(t) < span_len) && ((REG_W+1)'(t) <= reach) &&
          ((REG_W+1)'(t) + (REG_W+1)'(width) > reach)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

### rtl/core/bod_colmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bod_colmem
// Per-column row distance store: one write and one registered read a cycle,
// with the same-cycle write passed through to the read.
// ----------------------------------------------------------------------------
module bod_colmem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [bod_pkg::COL_W-1:0] rd_addr,
  input  logic                      wr_en,
  input  logic [bod_pkg::COL_W-1:0] wr_addr,
  input  logic [bod_pkg::CNT_W-1:0] wr_data,
  output logic [bod_pkg::CNT_W-1:0] rd_data
);
  import bod_pkg::*;

  logic [CNT_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read with write-through on address match
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

### rtl/core/binary_obstacle_dilation_unit.sv
`timescale 1ns / 1ps
// Latency: an item's result leaves radius*width+radius items later; each
//   accepted item passes through the evaluation stage into the output register.
// Throughput: one item per cycle while the output is not stalled, set by one
//   read and one write of the column distance store per item.
// Reset: synchronous; counters clear, registers take their defaults, the
//   stores need no clearing pass.
// ----------------------------------------------------------------------------
// binary_obstacle_dilation_unit
// Square dilation of a raster occupancy stream: horizontal span from a short
// pixel history, vertical span from a per-column row distance.
// ----------------------------------------------------------------------------
module binary_obstacle_dilation_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bod_pkg::IDX_W-1:0] cfg_index,
  input  logic [bod_pkg::REG_W-1:0] cfg_wdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,   // red, green, blue
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // inflated, out_row, out_col
  output logic                      m_axis_tlast    // frame_last
);
  import bod_pkg::*;

  logic [REG_W-1:0] width_reg, height_reg;
  logic [RAD_W-1:0] radius_reg;
  logic [REG_W-1:0] w, h;
  logic [RAD_W-1:0] r;

  logic [COL_W-1:0] in_col, j_col;
  logic [ROW_W-1:0] in_row, j_row;
  logic [RAD_W-1:0] pre;
  logic             accept, jv_now, occ, frame_end;

  logic             s1_valid, s1_jv;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             out_free, s1_free, hit, wr_en;
  logic [CNT_W-1:0] rd_data, dist_next;
  logic [ROW_W-1:0] k_row;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= REG_W'(MAX_WIDTH);
      height_reg <= REG_W'(MAX_HEIGHT);
      radius_reg <= RAD_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_reg  <= cfg_wdata;
        REG_HEIGHT: height_reg <= cfg_wdata;
        REG_RADIUS: radius_reg <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  always_comb begin
    w = (width_reg == '0) ? REG_W'(1) :
        (width_reg > REG_W'(MAX_WIDTH)) ? REG_W'(MAX_WIDTH) : width_reg;
    h = (height_reg == '0) ? REG_W'(1) :
        (height_reg > REG_W'(MAX_HEIGHT)) ? REG_W'(MAX_HEIGHT) : height_reg;
    r = (radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_reg;
  end

  // handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_free       = !s1_valid || out_free;
  assign s_axis_tready = s1_free;
  assign accept        = s_axis_tvalid && s1_free;

  // input side: occupancy and evaluated position
  assign occ       = (ROW_W'(in_row) < ROW_W'(h)) && (s_axis_tdata == 24'd0);
  assign jv_now    = (pre >= r);
  assign frame_end = jv_now && (j_row == ROW_W'(h) + ROW_W'(r) - ROW_W'(1)) &&
                     ((REG_W)'(j_col) == w - REG_W'(1));

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
      j_col  <= '0;
      j_row  <= '0;
      pre    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        in_col <= '0;
        in_row <= '0;
        j_col  <= '0;
        j_row  <= '0;
        pre    <= '0;
      end else begin
        if (REG_W'(in_col) + REG_W'(1) >= w) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (!jv_now) begin
          pre <= pre + RAD_W'(1);
        end else if (REG_W'(j_col) + REG_W'(1) >= w) begin
          j_col <= '0;
          j_row <= j_row + ROW_W'(1);
        end else begin
          j_col <= j_col + COL_W'(1);
        end
      end
    end
  end

  bod_hspan u_hspan (
    .clk      (clk),
    .shift_en (accept),
    .occ_in   (occ),
    .col      (s1_col),
    .width    (w),
    .radius   (r),
    .hit      (hit)
  );

  assign wr_en = s1_valid && s1_jv && out_free;

  bod_colmem u_colmem (
    .clk     (clk),
    .rd_en   (accept && jv_now),
    .rd_addr (j_col),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (dist_next),
    .rd_data (rd_data)
  );

  // rows since the last horizontal hit in this column
  always_comb begin
    if (hit) begin
      dist_next = '0;
    end else if (s1_row == '0 || rd_data == DIST_SAT) begin
      dist_next = DIST_SAT;
    end else begin
      dist_next = rd_data + CNT_W'(1);
    end
    k_row = s1_row - ROW_W'(r);
  end

  // evaluation stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_jv  <= jv_now;
      s1_row <= j_row;
      s1_col <= j_col;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_valid && s1_jv && (s1_row >= ROW_W'(r));
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_axis_tdata <= {3'b000, s1_col, k_row[COL_W-1:0],
                       (dist_next < CNT_W'({r, 1'b0}))};
      m_axis_tlast <= (k_row == ROW_W'(h) - ROW_W'(1)) &&
                      (REG_W'(s1_col) == w - REG_W'(1));
    end
  end

endmodule

### rtl/core/bod_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bod_checker
// Port-level checks for the dilation unit, bound to the top level.
// ----------------------------------------------------------------------------
module bod_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // input only stalls behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000)
    else $error("tdata padding not zero");

endmodule

bind binary_obstacle_dilation_unit bod_checker u_bod_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_obstacle_dilation_unit. Each frame is set up
// while the block is idle. Pixels and padding items go in under random
// backpressure. A local model of the line store predicts the dilated cells, but
// typed rows carry their own; each output item is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
  import bod_pkg::*;

  typedef struct packed {
    logic       frame_last;
    logic [9:0] col;
    logic [9:0] row;
    logic       inflated;
  } cell_t;

  typedef struct {
    logic [23:0] rgb;
    bit          typed;
    cell_t       exp_item;
  } dir_row_t;

  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;

  logic             clk = 0;
  logic             rst = 1;
  logic             cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [REG_W-1:0] cfg_wdata = '0;
  logic             s_axis_tvalid = 0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 0;
  logic [23:0]      m_axis_tdata;
  logic             m_axis_tlast;

  binary_obstacle_dilation_unit dut (.*);

  // shadow registers and line store of the predictor
  logic [10:0] width_reg = 11'd1024, height_reg = 11'd1024;
  logic [4:0]  radius_reg = 5'd3;
  bit          occ_store [DEPTH];
  int unsigned frame_pos = 0;

  cell_t cell_q[$];
  int    errors = 0;
  int    items_sent = 0, cells_seen = 0, frames_done = 0;
  bit    no_idle = 0;
  bit    hold_req = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #5ms;
    $display("binary_obstacle_dilation_unit regression: fail");
    $finish;
  end

  // clamped geometry of the current setting
  function automatic int unsigned cur_w();
    return (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
  endfunction
  function automatic int unsigned cur_h();
    return (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
  endfunction
  function automatic int unsigned cur_r();
    return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
  endfunction

  // advance the dilation predictor by one item; returns 1 with a cell if due
  function automatic bit dilate_step(input logic [23:0] rgb, output cell_t c);
    int unsigned w, h, r, pixels, lag, q;
    int k, m, a0, a1, b0, b1;
    bit hit;
    w = cur_w(); h = cur_h(); r = cur_r();
    pixels = w * h;
    lag = r * w + r;
    if (frame_pos >= pixels + lag) frame_pos = 0;
    if (frame_pos < pixels) occ_store[frame_pos % DEPTH] = (rgb == 24'd0);
    dilate_step = 0;
    c = '0;
    if (frame_pos >= lag) begin
      q = frame_pos - lag;
      k = q / w; m = q % w;
      a0 = k - int'(r) + 1; a1 = k + int'(r);
      b0 = m - int'(r) + 1; b1 = m + int'(r);
      if (a0 < 0) a0 = 0;
      if (a1 > int'(h) - 1) a1 = h - 1;
      if (b0 < 0) b0 = 0;
      if (b1 > int'(w) - 1) b1 = w - 1;
      hit = 0;
      for (int a = a0; a <= a1; a++)
        for (int b = b0; b <= b1; b++)
          if (occ_store[(a * w + b) % DEPTH]) hit = 1;
      c.inflated = hit;
      c.row = k[9:0];
      c.col = m[9:0];
      c.frame_last = (q == pixels - 1);
      dilate_step = 1;
    end
    frame_pos++;
    if (frame_pos >= pixels + lag) frame_pos = 0;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      default:    radius_reg = val[4:0];
    endcase
  endtask

  // drain all expected cells, let the pipeline settle, then set up a frame
  task automatic setup_frame(input logic [10:0] w, input logic [10:0] h,
                             input logic [4:0] r);
    wait (cell_q.size() == 0);
    repeat (8) @(posedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, {6'd0, r});
  endtask

  // offer one item, entered at a falling edge; typed rows carry their own cell
  task automatic send_item(input logic [23:0] rgb, input bit typed, input cell_t tc);
    cell_t c;
    if (!no_idle) begin
      while ($urandom_range(99) < 34) begin
        s_axis_tvalid = 0;
        @(negedge clk);
      end
    end
    s_axis_tvalid = 1;
    s_axis_tdata = rgb;
    do @(posedge clk); while (!s_axis_tready);
    if (dilate_step(rgb, c)) cell_q.push_back(typed ? tc : c);
    items_sent++;
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(9))
      0, 1, 2: return 24'd0;
      3:       return 24'hFFFFFF;
      4:       return 24'hFF << (8 * $urandom_range(2));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_frame(input logic [10:0] w, input logic [10:0] h, input logic [4:0] r);
    int unsigned total, cw, ch, cr;
    setup_frame(w, h, r);
    cw = cur_w(); ch = cur_h(); cr = cur_r();
    total = cw * ch + cr * cw + cr;
    for (int i = 0; i < total; i++) send_item(rand_pixel(), 0, '0);
    frames_done++;
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 0;
        for (hold = 0; hold < 300; hold++) @(negedge clk);
        hold_req = 0;
      end
      m_axis_tready = no_idle ? 1'b1 : ($urandom_range(99) >= 34);
    end
  end

  // output checker
  always @(posedge clk) begin
    cell_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{frame_last: m_axis_tlast, col: m_axis_tdata[20:11],
              row: m_axis_tdata[10:1], inflated: m_axis_tdata[0]};
      cells_seen++;
      if (cell_q.size() == 0) begin
        $error("unexpected output item row %0d col %0d", got.row, got.col);
        errors++;
      end else begin
        want = cell_q.pop_front();
        if (got.inflated !== want.inflated) begin
          $error("inflated: expected %0d, got %0d", want.inflated, got.inflated); errors++;
        end
        if (got.row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, got.row); errors++;
        end
        if (got.col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, got.col); errors++;
        end
        if (got.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
          errors++;
        end
        if (m_axis_tdata[23:21] !== 3'b000) begin
          $error("tdata pad: expected 0, got %0d", m_axis_tdata[23:21]); errors++;
        end
      end
    end
  end

  // directed frames: radius zero 3x2 (all clear, typed), then 4x2 radius 1
  dir_row_t dir_tab [19];
  initial begin
    logic [23:0] dpix [13] = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                               24'hFF0000, 24'h010101, 24'h000000, 24'h808080,
                               24'hABCDEF, 24'h000000, 24'h123456, 24'hFFFFFF, 24'h000000};
    for (int i = 0; i < 6; i++)
      dir_tab[i] = '{rgb: (i % 2) ? 24'hFFFFFF : 24'h000000, typed: 1,
                     exp_item: '{frame_last: (i == 5), col: 10'(i % 3),
                                 row: 10'(i / 3), inflated: 1'b0}};
    for (int i = 0; i < 13; i++) dir_tab[6 + i] = '{rgb: dpix[i], typed: 0, exp_item: '0};
  end

  initial begin
    int spare;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed part
    for (int i = 0; i < 19; i++) begin
      if (i == 0) setup_frame(11'd3, 11'd2, 5'd0);
      if (i == 6) setup_frame(11'd4, 11'd2, 5'd1);
      send_item(dir_tab[i].rgb, dir_tab[i].typed, dir_tab[i].exp_item);
    end

    // extremes: zero width and height with clamped radius, then full radius
    run_frame(11'd0, 11'd0, 5'd31);
    run_frame(11'd5, 11'd3, 5'd16);

    // random frames, mostly small, with one hold-off and one clean stretch
    spare = 0;
    while (spare < 1100) begin
      if (frames_done == 4) hold_req = 1;
      no_idle = (frames_done >= 6 && frames_done < 10);
      case ($urandom_range(9))
        0:       run_frame(11'($urandom_range(24)), 11'($urandom_range(3)),
                           5'($urandom_range(31)));
        default: run_frame(11'($urandom_range(1, 12)), 11'($urandom_range(1, 6)),
                           5'($urandom_range(0, 4)));
      endcase
      spare = items_sent;
    end
    no_idle = 0;

    wait (cell_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d items over %0d frames, %0d cells checked",
             items_sent, frames_done + 2, cells_seen);
    $display("settings included zero width and height, radius above the limit and radius zero");
    if (errors == 0 && cell_q.size() == 0)
      $display("binary_obstacle_dilation_unit regression: pass");
    else
      $display("binary_obstacle_dilation_unit regression: fail");
    $finish;
  end

endmodule
